### hdl/pnc_pkg.sv
// Shared widths and the controller-to-datapath command and status types.
package pnc_pkg;

  localparam int unsigned NumberBits = 16;
  localparam int unsigned SumBits    = 20;
  localparam int unsigned CountBits  = $clog2(NumberBits);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the number and start the first trial division
    logic div_step;  // one restoring-division bit step
    logic accum;     // unless stop: add the divisor pair if d divides n, start the next trial division
    logic publish;   // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;  // the current division step is the final one
    logic stop;      // the trial divisor has passed the square root
    logic out_busy;  // the output register holds a result that is stalled
  } status_t;

endpackage

### hdl/pnc_dp.sv
// Datapath: trial divisor, bit-serial remainder unit, divisor sum and output register.
module pnc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pnc_pkg::cmd_t                cmd_i,
  output pnc_pkg::status_t             status_o,
  input  logic [pnc_pkg::NumberBits-1:0] number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_perfect_o,
  output logic [pnc_pkg::SumBits-1:0]  divisor_sum_o
);

  logic [pnc_pkg::NumberBits-1:0] n_q, d_q, rem_q, quo_q;
  logic [pnc_pkg::NumberBits-1:0] n_d, d_d, rem_d, quo_d;
  logic [pnc_pkg::CountBits-1:0]  cnt_q, cnt_d;
  logic [pnc_pkg::SumBits-1:0]    sum_q, sum_d;
  logic                           out_valid_q, out_valid_d;
  logic                           perfect_q, perfect_d;
  logic [pnc_pkg::SumBits-1:0]    res_q, res_d;

  logic [pnc_pkg::NumberBits:0]   trial;
  logic [pnc_pkg::NumberBits:0]   trial_diff;
  logic                           fits;
  logic [pnc_pkg::SumBits-1:0]    pair_add;
  logic [pnc_pkg::SumBits-1:0]    proper_sum;
  logic [pnc_pkg::SumBits-1:0]    n_wide;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial      = {rem_q, n_q[cnt_q]};
  assign trial_diff = trial - {1'b0, d_q};
  assign fits       = (trial >= {1'b0, d_q});

  // Divisor d and its partner n/d; the partner is skipped when it equals d.
  assign pair_add = pnc_pkg::SumBits'(d_q)
                  + ((quo_q != d_q) ? pnc_pkg::SumBits'(quo_q) : '0);

  assign n_wide     = pnc_pkg::SumBits'(n_q);
  assign proper_sum = sum_q - n_wide;

  assign status_o.div_last = (cnt_q == '0);
  assign status_o.stop     = (d_q > quo_q);
  assign status_o.out_busy = out_valid_q & out_stall_i;

  always_comb begin
    n_d         = n_q;
    d_d         = d_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    perfect_d   = perfect_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.load) begin
      n_d   = number_i;
      d_d   = pnc_pkg::NumberBits'(1);
      rem_d = '0;
      quo_d = '0;
      cnt_d = pnc_pkg::CountBits'(pnc_pkg::NumberBits - 1);
      sum_d = '0;
    end
    if (cmd_i.div_step) begin
      rem_d = fits ? trial_diff[pnc_pkg::NumberBits-1:0] : trial[pnc_pkg::NumberBits-1:0];
      quo_d = {quo_q[pnc_pkg::NumberBits-2:0], fits};
      cnt_d = cnt_q - pnc_pkg::CountBits'(1);
    end
    if (cmd_i.accum && !status_o.stop) begin
      if (rem_q == '0) begin
        sum_d = sum_q + pair_add;
      end
      d_d   = d_q + pnc_pkg::NumberBits'(1);
      rem_d = '0;
      quo_d = '0;
      cnt_d = pnc_pkg::CountBits'(pnc_pkg::NumberBits - 1);
    end
    if (cmd_i.publish) begin
      res_d       = proper_sum;
      perfect_d   = (n_q >= pnc_pkg::NumberBits'(2)) && (proper_sum == n_wide);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    d_q       <= d_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    sum_q     <= sum_d;
    perfect_q <= perfect_d;
    res_q     <= res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign is_perfect_o  = perfect_q;
  assign divisor_sum_o = res_q;

  // A new result must never overwrite one that is still stalled at the output.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> !(out_valid_q && out_stall_i))
    else $error("result published over a stalled output");

endmodule

### hdl/pnc_ctrl.sv
// Controller: sequences loading, trial divisions, accumulation and publishing.
module pnc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pnc_pkg::status_t status_i,
  output pnc_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_ACC  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = status_i.stop ? S_FIN : S_DIV;
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_DIV))
    else $error("accepted number did not start a division");

  a_acc_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> $past(state_q == S_DIV && status_i.div_last))
    else $error("accumulate step without a finished division");

  a_publish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |=> (state_q == S_IDLE))
    else $error("controller did not return to idle after publishing");

endmodule

### hdl/perfect_number_check.sv
// Top level of the perfect number checker: controller plus datapath.
//
// Each transfer on the input channel brings one 16-bit unsigned number; the
// block returns one transfer with the sum of its proper divisors (divisor 1
// included, the number itself excluded) and a flag that is set when that sum
// equals the number. Zero and one give a sum of 0 and are never perfect.
// Divisors are found in pairs d and n/d, trying d = 1, 2, 3, ... until d
// exceeds n/d, so about sqrt(n) + 1 trial divisors are run. Each trial is a
// restoring division done one bit per cycle in a single shared remainder unit,
// followed by an accumulate step, so the run time of a number grows with
// floor(sqrt(n)) + 1, plus any output stall, and is longest for any n from
// 65025 up to 65535. One number is worked on at a time; input stall is low
// only while the controller is idle. The result sits in an output register,
// so a new number is accepted as soon as the previous result has been
// published, even if that result is still waiting to be taken.
module perfect_number_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [pnc_pkg::NumberBits-1:0]  number_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            is_perfect_o,
  output logic [pnc_pkg::SumBits-1:0]     divisor_sum_o
);

  pnc_pkg::cmd_t    cmd;
  pnc_pkg::status_t status;

  // The controller only steps through the phases; all arithmetic lives in the
  // datapath.
  pnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pnc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .number_i      (number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_perfect_o  (is_perfect_o),
    .divisor_sum_o (divisor_sum_o)
  );

endmodule

### dv/testbench.sv
// Self-checking testbench for the perfect number checker: directed and random numbers.

module testbench;

  // Top of the 20-bit sum field; the model clamps its expected sum to it.
  localparam int unsigned SumMax       = (1 << pnc_pkg::SumBits) - 1;
  localparam int unsigned RandomItems  = 76;
  // Results checked before the receiver holds off for a long stretch.
  localparam int unsigned HoldAfter    = 40;
  // The hold-off runs well past the time needed to finish one number, so the
  // output register fills, the next number completes and the input stalls.
  localparam int unsigned HoldCycles   = 12000;
  // Drain time after the last result: about one worst-case number.
  localparam int unsigned DrainCycles  = 4500;
  // Every number at its slowest plus gaps, stalls and the hold-off, taken a few
  // times over.
  localparam int unsigned CycleLimit   = 2000000;

  // Expected outcome for one number.
  typedef struct packed {
    logic [pnc_pkg::NumberBits-1:0] number;
    logic                           is_perfect;
    logic [pnc_pkg::SumBits-1:0]    divisor_sum;
  } divisor_result_t;

  // Receiver stall styles; each one lasts for a segment of random length.
  typedef enum logic [1:0] {
    StallNever,
    StallLight,
    StallHeavy,
    StallAlternate
  } stall_style_e;

  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  logic [pnc_pkg::NumberBits-1:0] number    = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           is_perfect;
  logic [pnc_pkg::SumBits-1:0]    divisor_sum;

  // Numbers waiting to be offered, and outcomes waiting for their result.
  logic [pnc_pkg::NumberBits-1:0] numbers_to_send_q[$];
  divisor_result_t                awaited_results_q[$];
  divisor_result_t                oldest_result;

  int unsigned   burst_left      = 0;
  int unsigned   gap_left        = 0;
  int unsigned   segment_left    = 0;
  int unsigned   hold_left       = 0;
  bit            hold_done       = 1'b0;
  stall_style_e  stall_style     = StallNever;
  int unsigned   results_checked = 0;
  int unsigned   fail_count      = 0;
  int unsigned   cycle_count     = 0;
  int unsigned   pick;

  perfect_number_check u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .number_i      (number),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .is_perfect_o  (is_perfect),
    .divisor_sum_o (divisor_sum)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Sum of the proper divisors of a number, with divisor 1 included and the
  // number itself left out. Divisors are collected in pairs d and n/d up to
  // the square root; zero and one have no proper divisors worth counting.
  function automatic divisor_result_t sum_proper_divisors(
    input logic [pnc_pkg::NumberBits-1:0] value
  );
    int unsigned     n;
    int unsigned     d;
    int unsigned     total;
    divisor_result_t outcome;
    n     = value;
    total = 0;
    if (n >= 2) begin
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          total += d;
          if (n / d != d) total += n / d;
        end
      end
      total -= n;
    end
    outcome.number      = value;
    outcome.is_perfect  = (n >= 2) && (total == n);
    outcome.divisor_sum = (total > SumMax) ? pnc_pkg::SumBits'(SumMax)
                                           : pnc_pkg::SumBits'(total);
    return outcome;
  endfunction

  // Driver. The payload may change only when no transfer is pending or the
  // current one completes at this edge. The sender works in bursts with gaps
  // in between; a completed transfer queues the predicted outcome.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      number     <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) awaited_results_q.push_back(sum_proper_divisors(number));
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (numbers_to_send_q.size() > 0) begin
        in_valid <= 1'b1;
        number   <= numbers_to_send_q.pop_front();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // Now and then a long burst with no idle cycles at all.
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            gap_left   = $urandom_range(0, 8);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. Stalls follow a style picked anew every segment. Once, after
  // a number of results, it holds off for a long stretch while the sender
  // keeps offering numbers, so the block backs up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      segment_left = 0;
      hold_left    = 0;
      stall_style  = StallNever;
    end else begin
      if (!hold_done && results_checked >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (segment_left == 0) begin
          segment_left = $urandom_range(20, 200);
          stall_style  = stall_style_e'($urandom_range(0, 3));
        end else begin
          segment_left--;
        end
        case (stall_style)
          StallNever:     out_stall <= 1'b0;
          StallLight:     out_stall <= ($urandom_range(0, 3) == 0);
          StallHeavy:     out_stall <= ($urandom_range(0, 3) != 0);
          StallAlternate: out_stall <= ~out_stall;
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Monitor. Every completed output transfer is matched against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (awaited_results_q.size() == 0) begin
        $error("result with no number outstanding: is_perfect %0d divisor_sum %0d",
               is_perfect, divisor_sum);
        fail_count++;
      end else begin
        oldest_result = awaited_results_q.pop_front();
        if (is_perfect !== oldest_result.is_perfect) begin
          $error("number %0d: is_perfect expected %0d actual %0d",
                 oldest_result.number, oldest_result.is_perfect, is_perfect);
          fail_count++;
        end
        if (divisor_sum !== oldest_result.divisor_sum) begin
          $error("number %0d: divisor_sum expected %0d actual %0d",
                 oldest_result.number, oldest_result.divisor_sum, divisor_sum);
          fail_count++;
        end
        results_checked <= results_checked + 1;
      end
    end
  end

  // The run stops here if the block hangs.
  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    // Directed numbers: zero and one, the smallest primes, every perfect
    // number that fits in 16 bits, squares (where d equals n/d), an odd
    // abundant number, powers of two, and the top of the range.
    numbers_to_send_q = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd6, 16'd7, 16'd9,
                          16'd12, 16'd16, 16'd24, 16'd28, 16'd496, 16'd945,
                          16'd8128, 16'd256, 16'd10000, 16'd32768, 16'd65025,
                          16'd65521, 16'd65534, 16'd65535, 16'd43690, 16'd21845};
    // Random numbers. Most are small because run time grows with the square
    // root of the number; a few span the whole range to exercise every bit,
    // and perfect numbers show up now and then.
    for (k = 0; k < RandomItems; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       numbers_to_send_q.push_back(16'd6);
          1:       numbers_to_send_q.push_back(16'd28);
          2:       numbers_to_send_q.push_back(16'd496);
          default: numbers_to_send_q.push_back(16'd8128);
        endcase
      end else if (pick < 15) begin
        numbers_to_send_q.push_back(pnc_pkg::NumberBits'($urandom_range(0, 3)));
      end else if (pick < 70) begin
        numbers_to_send_q.push_back(pnc_pkg::NumberBits'($urandom_range(0, 1023)));
      end else if (pick < 85) begin
        numbers_to_send_q.push_back(pnc_pkg::NumberBits'($urandom_range(1024, 8191)));
      end else begin
        numbers_to_send_q.push_back(pnc_pkg::NumberBits'($urandom));
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every number has been sent and every result has come back,
    // then give the block time to show any stray result.
    while (numbers_to_send_q.size() > 0 || in_valid || awaited_results_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
